/* rtl/mhpq_pkg.sv */
// Shared types and constants for the max-heap priority queue.
package mhpq_pkg;

   localparam int DEFAULT_CAPACITY = 64;
   localparam int VALUE_WIDTH      = 32;
   localparam int COUNT_WIDTH      = 7;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type                        cmd;
      logic signed [VALUE_WIDTH-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type                     status;
      logic signed [VALUE_WIDTH-1:0]  removed_value;
      logic signed [VALUE_WIDTH-1:0]  top_value;
      logic [COUNT_WIDTH-1:0]         count;
   } rsp_type;

endpackage

/* rtl/max_heap_priority_queue_top.sv */
// Max-heap priority queue: heap held in a two-read, one-write synchronous memory.
// Insert and remove alike walk the heap one level per memory read round trip. One item
// at a time: the next item is taken only once the result is loaded and the queue is idle.
// Reset clears the count, the state machine and the result valid; the heap memory is not
// cleared, only entries below the count are ever used.
module max_heap_priority_queue_top #(
   parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mhpq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mhpq_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int IW = CW + 1;
   localparam int VW = mhpq_pkg::VALUE_WIDTH;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_UP     = 6'b000010,
      ST_DN_X   = 6'b000100,
      ST_DN_CMP = 6'b001000,
      ST_FIN_WR = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           pos_ff, pos_in;
   logic signed [VW-1:0]    x_ff, x_in;
   logic signed [VW-1:0]    top_ff, top_in;
   mhpq_pkg::status_type    status_ff, status_in;
   logic signed [VW-1:0]    removed_ff, removed_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   mhpq_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   logic signed [VW-1:0]    heap_mem [CAPACITY];
   logic signed [VW-1:0]    rd0_ff, rd1_ff;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic signed [VW-1:0]    wr_data;
   logic [AW-1:0]           rd_addr0, rd_addr1;

   logic [CW-1:0]           cnt_inc;
   logic [CW-1:0]           par;
   logic [IW-1:0]           lft, rgt, n_ext, big, child_left;
   logic                    pick_right;
   logic signed [VW-1:0]    big_val;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign cnt_inc    = count_ff + CW'(1);
   assign par        = pos_ff >> 1;
   assign lft        = {pos_ff, 1'b0};
   assign rgt        = lft + IW'(1);
   assign n_ext      = {1'b0, count_ff};
   assign pick_right = (rgt <= n_ext) && (rd0_ff < rd1_ff);
   assign big        = pick_right ? rgt : lft;
   assign big_val    = pick_right ? rd1_ff : rd0_ff;
   assign child_left = {big[CW-1:0], 1'b0};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      x_in         = x_ff;
      top_in       = top_ff;
      status_in    = status_ff;
      removed_in   = removed_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = AW'(pos_ff - CW'(1));
      wr_data      = x_ff;
      rd_addr0     = '0;
      rd_addr1     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               status_in  = mhpq_pkg::STATUS_OK;
               removed_in = '0;
               if (req_data.cmd == mhpq_pkg::CMD_INSERT) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     status_in = mhpq_pkg::STATUS_FULL;
                     state_in  = ST_DONE;
                  end else if (count_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_data  = req_data.value;
                     top_in   = req_data.value;
                     count_in = CW'(1);
                     state_in = ST_DONE;
                  end else begin
                     // open a hole at the end, fetch its parent
                     count_in = cnt_inc;
                     pos_in   = cnt_inc;
                     x_in     = req_data.value;
                     rd_addr0 = AW'((cnt_inc >> 1) - CW'(1));
                     state_in = ST_UP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = mhpq_pkg::STATUS_EMPTY;
                     state_in  = ST_DONE;
                  end else begin
                     removed_in = top_ff;
                     count_in   = count_ff - CW'(1);
                     pos_in     = CW'(1);
                     if (count_ff == CW'(1)) begin
                        state_in = ST_DONE;
                     end else begin
                        // fetch the last element, it refills the root
                        rd_addr0 = AW'(count_ff - CW'(1));
                        state_in = ST_DN_X;
                     end
                  end
               end
            end
         end
         ST_UP: begin
            if (rd0_ff < x_ff) begin
               // move the parent down into the hole
               wr_en   = 1'b1;
               wr_data = rd0_ff;
               if (par == CW'(1)) begin
                  pos_in   = CW'(1);
                  state_in = ST_FIN_WR;
               end else begin
                  pos_in   = par;
                  rd_addr0 = AW'((par >> 1) - CW'(1));
               end
            end else begin
               wr_en    = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DN_X: begin
            x_in = rd0_ff;
            if (count_ff == CW'(1)) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = rd0_ff;
               top_in   = rd0_ff;
               state_in = ST_DONE;
            end else begin
               rd_addr0 = AW'(1);
               rd_addr1 = AW'(2);
               state_in = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            if (x_ff < big_val) begin
               // lift the larger child into the hole
               wr_en   = 1'b1;
               wr_data = big_val;
               if (pos_ff == CW'(1)) begin
                  top_in = big_val;
               end
               pos_in = big[CW-1:0];
               if (child_left > n_ext) begin
                  state_in = ST_FIN_WR;
               end else begin
                  rd_addr0 = AW'(child_left - IW'(1));
                  rd_addr1 = AW'(child_left);
               end
            end else begin
               wr_en = 1'b1;
               if (pos_ff == CW'(1)) begin
                  top_in = x_ff;
               end
               state_in = ST_DONE;
            end
         end
         ST_FIN_WR: begin
            wr_en = 1'b1;
            if (pos_ff == CW'(1)) begin
               top_in = x_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = status_ff;
               rsp_data_in.removed_value = removed_ff;
               rsp_data_in.top_value     = (count_ff != '0) ? top_ff : '0;
               rsp_data_in.count         = mhpq_pkg::COUNT_WIDTH'(count_ff);
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      x_ff        <= x_in;
      top_ff      <= top_in;
      status_ff   <= status_in;
      removed_ff  <= removed_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd0_ff <= heap_mem[rd_addr0];
      rd1_ff <= heap_mem[rd_addr1];
   end

`ifndef ASSERT_OFF
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("queue idle right after an input transfer");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("element count above capacity");

   a_count_changes_on_transfer: assert property (@(posedge clock) disable iff (reset)
      (!$stable(count_ff) && !$past(reset)) |-> $past(state_ff == ST_IDLE))
      else $error("element count changed outside an input transfer");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && !$past(reset)) |-> $past(state_ff == ST_DONE))
      else $error("result loaded before the operation finished");

   a_sift_down_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DN_CMP) |-> (lft <= n_ext))
      else $error("sift-down compares past the last element");
`endif

endmodule

/* tb/sv/tb_max_heap_priority_queue_top.sv */
// Self-checking testbench for the max-heap priority queue: directed table, then random phases.
module tb_max_heap_priority_queue_top;

   localparam int CAPACITY     = mhpq_pkg::DEFAULT_CAPACITY;
   localparam int VW           = mhpq_pkg::VALUE_WIDTH;
   localparam int RANDOM_ITEMS = 800;
   localparam int TAIL_CYCLES  = 24;

   localparam logic signed [VW-1:0] VAL_MAX = 32'sh7FFFFFFF;
   localparam logic signed [VW-1:0] VAL_MIN = 32'sh80000000;

   typedef struct {
      mhpq_pkg::req_type item;
      bit                known;
      mhpq_pkg::rsp_type want;
   } table_row_type;

   typedef struct {
      bit                known;
      mhpq_pkg::rsp_type want;
   } row_note_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   mhpq_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   mhpq_pkg::rsp_type rsp_data;

   // heap as the block should hold it
   logic signed [VW-1:0] heap_model [1:CAPACITY];
   int heap_size = 0;

   mhpq_pkg::rsp_type expected_rsps [$];
   row_note_type      typed_notes [$];
   table_row_type     directed_rows [$];

   int  error_count   = 0;
   int  items_sent    = 0;
   int  results_seen  = 0;
   int  full_drops    = 0;
   int  empty_pops    = 0;
   int  deepest       = 0;
   int  stall_left    = 0;
   int  planned_count = 0;
   bit  quiet         = 1'b0;

   max_heap_priority_queue_top #(.CAPACITY(CAPACITY)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic mhpq_pkg::rsp_type heap_predict(input mhpq_pkg::req_type item);
      mhpq_pkg::rsp_type res;
      int pos, par, lft, rgt, big;
      bit done;
      logic signed [VW-1:0] tmp;
      res = '{status: mhpq_pkg::STATUS_OK, removed_value: '0, top_value: '0, count: '0};
      if (item.cmd == mhpq_pkg::CMD_INSERT) begin
         if (heap_size >= CAPACITY) begin
            res.status = mhpq_pkg::STATUS_FULL;
         end else begin
            heap_size++;
            heap_model[heap_size] = item.value;
            pos  = heap_size;
            done = 1'b0;
            // climb while the parent is strictly smaller
            while (pos > 1 && !done) begin
               par = pos >> 1;
               if (heap_model[par] < heap_model[pos]) begin
                  tmp             = heap_model[par];
                  heap_model[par] = heap_model[pos];
                  heap_model[pos] = tmp;
                  pos             = par;
               end else begin
                  done = 1'b1;
               end
            end
         end
      end else begin
         if (heap_size == 0) begin
            res.status = mhpq_pkg::STATUS_EMPTY;
         end else begin
            res.removed_value = heap_model[1];
            heap_model[1]     = heap_model[heap_size];
            heap_size--;
            pos  = 1;
            done = 1'b0;
            // descend towards the larger child while it is strictly greater
            while (!done) begin
               lft = pos * 2;
               rgt = lft + 1;
               if (lft > heap_size) begin
                  done = 1'b1;
               end else begin
                  big = lft;
                  if (rgt <= heap_size && heap_model[lft] < heap_model[rgt]) big = rgt;
                  if (heap_model[pos] < heap_model[big]) begin
                     tmp             = heap_model[pos];
                     heap_model[pos] = heap_model[big];
                     heap_model[big] = tmp;
                     pos             = big;
                  end else begin
                     done = 1'b1;
                  end
               end
            end
         end
      end
      res.top_value = (heap_size > 0) ? heap_model[1] : '0;
      res.count     = heap_size[mhpq_pkg::COUNT_WIDTH-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at result %0d: %s", results_seen, what);
      error_count++;
   endtask

   task automatic check_result(input mhpq_pkg::rsp_type got);
      mhpq_pkg::rsp_type want;
      if (expected_rsps.size() == 0) begin
         report_mismatch("result with nothing outstanding");
      end else begin
         want = expected_rsps.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.removed_value !== want.removed_value)
            report_mismatch($sformatf("removed %0d, want %0d",
                                      got.removed_value, want.removed_value));
         if (got.top_value !== want.top_value)
            report_mismatch($sformatf("top %0d, want %0d", got.top_value, want.top_value));
         if (got.count !== want.count)
            report_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
      end
   endtask

   // Request monitor, predictor and result checker in one process, so the
   // expectation of a transfer is queued before any result is compared.
   always @(posedge clock) begin
      mhpq_pkg::rsp_type pred;
      row_note_type      note;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left  = 0;
      end else begin
         if (req_valid && !req_stall) begin
            pred = heap_predict(req_data);
            if (pred.status == mhpq_pkg::STATUS_FULL) full_drops++;
            if (pred.status == mhpq_pkg::STATUS_EMPTY) empty_pops++;
            if (heap_size > deepest) deepest = heap_size;
            note = typed_notes.pop_front();
            expected_rsps.push_back(note.known ? note.want : pred);
         end
         if (rsp_valid && !rsp_stall) begin
            check_result(rsp_data);
            results_seen++;
            stall_left = quiet ? 0 : $urandom_range(0, 4);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   task automatic send_item(input mhpq_pkg::req_type item, input bit known,
                            input mhpq_pkg::rsp_type want);
      int gap;
      row_note_type note;
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      note.known = known;
      note.want  = want;
      typed_notes.push_back(note);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (item.cmd == mhpq_pkg::CMD_INSERT) begin
         if (planned_count < CAPACITY) planned_count++;
      end else if (planned_count > 0) begin
         planned_count--;
      end
   endtask

   task automatic send_random(input bit is_insert, input int style);
      mhpq_pkg::req_type item;
      logic signed [VW-1:0] val;
      case (style)
         1: begin
            case ($urandom_range(0, 4))
               0: val = VAL_MAX;
               1: val = VAL_MIN;
               2: val = 0;
               3: val = -1;
               default: val = 1;
            endcase
         end
         2: val = $signed($urandom_range(0, 8)) - 4;
         default: val = $urandom;
      endcase
      item.cmd   = is_insert ? mhpq_pkg::CMD_INSERT : mhpq_pkg::CMD_REMOVE;
      item.value = val;
      send_item(item, 1'b0, '0);
   endtask

   // Drop valid and hold until every outstanding result has been checked.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (results_seen == items_sent);
      @(posedge clock);
   endtask

   task automatic add_row(input mhpq_pkg::cmd_type cmd, input logic signed [VW-1:0] val,
                          input bit known, input mhpq_pkg::status_type st,
                          input logic signed [VW-1:0] removed,
                          input logic signed [VW-1:0] top, input int cnt);
      table_row_type row;
      row.item.cmd           = cmd;
      row.item.value         = val;
      row.known              = known;
      row.want.status        = st;
      row.want.removed_value = removed;
      row.want.top_value     = top;
      row.want.count         = cnt[mhpq_pkg::COUNT_WIDTH-1:0];
      directed_rows.push_back(row);
   endtask

   initial begin
      int random_sent, phase_no, phase_kind, phase_len, style, extra, k;
      random_sent = 0;
      phase_no    = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      add_row(mhpq_pkg::CMD_REMOVE, 0,       1, mhpq_pkg::STATUS_EMPTY, 0,       0,       0);
      add_row(mhpq_pkg::CMD_INSERT, VAL_MAX, 1, mhpq_pkg::STATUS_OK,    0,       VAL_MAX, 1);
      add_row(mhpq_pkg::CMD_INSERT, VAL_MIN, 1, mhpq_pkg::STATUS_OK,    0,       VAL_MAX, 2);
      add_row(mhpq_pkg::CMD_INSERT, 0,       1, mhpq_pkg::STATUS_OK,    0,       VAL_MAX, 3);
      add_row(mhpq_pkg::CMD_INSERT, VAL_MAX, 1, mhpq_pkg::STATUS_OK,    0,       VAL_MAX, 4);
      add_row(mhpq_pkg::CMD_REMOVE, 0,       1, mhpq_pkg::STATUS_OK,    VAL_MAX, VAL_MAX, 3);
      add_row(mhpq_pkg::CMD_REMOVE, 0,       1, mhpq_pkg::STATUS_OK,    VAL_MAX, 0,       2);
      add_row(mhpq_pkg::CMD_REMOVE, 0,       1, mhpq_pkg::STATUS_OK,    0,       VAL_MIN, 1);
      add_row(mhpq_pkg::CMD_REMOVE, 0,       1, mhpq_pkg::STATUS_OK,    VAL_MIN, 0,       0);
      add_row(mhpq_pkg::CMD_REMOVE, -1,      1, mhpq_pkg::STATUS_EMPTY, 0,       0,       0);
      add_row(mhpq_pkg::CMD_INSERT, -1,      1, mhpq_pkg::STATUS_OK,    0,       -1,      1);
      add_row(mhpq_pkg::CMD_INSERT, 1,       1, mhpq_pkg::STATUS_OK,    0,       1,       2);
      add_row(mhpq_pkg::CMD_INSERT, -2,      0, mhpq_pkg::STATUS_OK,    0,       0,       0);
      add_row(mhpq_pkg::CMD_INSERT, 5,       0, mhpq_pkg::STATUS_OK,    0,       0,       0);
      add_row(mhpq_pkg::CMD_INSERT, 5,       0, mhpq_pkg::STATUS_OK,    0,       0,       0);
      add_row(mhpq_pkg::CMD_INSERT, 3,       0, mhpq_pkg::STATUS_OK,    0,       0,       0);
      add_row(mhpq_pkg::CMD_INSERT, VAL_MIN, 0, mhpq_pkg::STATUS_OK,    0,       0,       0);
      add_row(mhpq_pkg::CMD_REMOVE, VAL_MAX, 0, mhpq_pkg::STATUS_OK,    0,       0,       0);
      add_row(mhpq_pkg::CMD_REMOVE, 0,       0, mhpq_pkg::STATUS_OK,    0,       0,       0);
      add_row(mhpq_pkg::CMD_INSERT, 4,       0, mhpq_pkg::STATUS_OK,    0,       0,       0);
      add_row(mhpq_pkg::CMD_REMOVE, 0,       0, mhpq_pkg::STATUS_OK,    0,       0,       0);

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].want);
      drain_results();

      while (random_sent < RANDOM_ITEMS) begin
         // open with a fill to overflow, then pick phases at random
         phase_kind = (phase_no == 0) ? 0 : $urandom_range(0, 4);
         style      = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
         quiet      = ($urandom_range(0, 4) == 0);
         case (phase_kind)
            0: begin
               extra = $urandom_range(1, 3);
               while (planned_count < CAPACITY) begin
                  send_random(1'b1, style);
                  random_sent++;
               end
               for (k = 0; k < extra; k++) begin
                  send_random(1'b1, $urandom_range(0, 2));
                  random_sent++;
               end
            end
            1: begin
               extra = $urandom_range(1, 2);
               while (planned_count > 0) begin
                  send_random(1'b0, 0);
                  random_sent++;
               end
               for (k = 0; k < extra; k++) begin
                  send_random(1'b0, 0);
                  random_sent++;
               end
            end
            default: begin
               phase_len = $urandom_range(20, 60);
               for (k = 0; k < phase_len; k++) begin
                  send_random(($urandom_range(0, 99) < 55), (phase_kind == 4) ? 2 : style);
                  random_sent++;
               end
            end
         endcase
         if (phase_no == 0 || $urandom_range(0, 4) == 0) drain_results();
         phase_no++;
      end

      quiet = 1'b0;
      req_valid <= 1'b0;
      wait (results_seen == items_sent);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_rsps.size()));

      $display("covered %0d transfers in %0d phases, peak occupancy %0d of %0d",
               items_sent, phase_no, deepest, CAPACITY);
      $display("full-heap inserts dropped %0d, removes on empty heap %0d, mismatches %0d",
               full_drops, empty_pops, error_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout: %0d transfers sent, %0d results seen", items_sent, results_seen);
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* sim.f */
rtl/mhpq_pkg.sv
rtl/max_heap_priority_queue_top.sv
tb/sv/tb_max_heap_priority_queue_top.sv
